### hdl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants of the probabilistic primality tester.
// ----------------------------------------------------------------------------
package ppt_pkg;

  // width of the number under test (8 to 64)
  localparam int NUMBER_BITS = 64;
  localparam int CAND_W      = 64;
  localparam int SEED_W      = 31;
  localparam int CNT_W       = $clog2(NUMBER_BITS + 1);
  localparam int SCNT_W      = $clog2(SEED_W + 1);

  typedef logic [NUMBER_BITS-1:0] num_t;

  localparam logic KIND_MR     = 1'b0;
  localparam logic KIND_FERMAT = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SMOD,
    S_STRIP,
    S_ESKIP,
    S_MDBL,
    S_MADD,
    S_MDONE,
    S_EVAL,
    S_MRCHK,
    S_DONE
  } eng_state_t;

  // what a finished modular multiply feeds
  typedef enum logic [1:0] {
    MP_SQ,
    MP_MUL,
    MP_MR
  } mul_use_t;

  // engine status toward the top level
  typedef struct packed {
    logic idle;
    logic done;
    logic pass;
    logic last;
  } eng_stat_t;

endpackage

### hdl/ppt_if.sv
// ----------------------------------------------------------------------------
// ppt_in_if / ppt_out_if
// Valid/ready channels for round requests and verdict results.
// ----------------------------------------------------------------------------
interface ppt_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] candidate;
  logic [30:0] witness_seed;
  logic        last_round;

  modport source (output valid, kind, candidate, witness_seed, last_round, input ready);
  modport sink   (input valid, kind, candidate, witness_seed, last_round, output ready);
endinterface

interface ppt_out_if;
  logic valid;
  logic ready;
  logic probably_prime;

  modport source (output valid, probably_prime, input ready);
  modport sink   (input valid, probably_prime, output ready);
endinterface

### hdl/ppt_modadd.sv
// ----------------------------------------------------------------------------
// ppt_modadd
// Shared modular adder: (a + b + cin) mod m, for a, b < m.
// ----------------------------------------------------------------------------
module ppt_modadd
  import ppt_pkg::*;
(
  input  num_t a,
  input  num_t b,
  input  logic cin,
  input  num_t m,
  output num_t sum
);

  logic [NUMBER_BITS:0] s;
  logic [NUMBER_BITS:0] diff;

  // sum stays below 2m, so one conditional subtract reduces it
  assign s    = {1'b0, a} + {1'b0, b} + {{NUMBER_BITS{1'b0}}, cin};
  assign diff = s - {1'b0, m};
  assign sum  = (s >= {1'b0, m}) ? diff[NUMBER_BITS-1:0] : s[NUMBER_BITS-1:0];

endmodule

### hdl/ppt_engine.sv
// ----------------------------------------------------------------------------
// ppt_engine
// Sequencer for one test round: witness reduction, exponent setup, square
// and multiply exponentiation and the Miller-Rabin squaring loop, all on
// one shared modular adder.
// ----------------------------------------------------------------------------
module ppt_engine
  import ppt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                kind,
  input  logic [CAND_W-1:0]   candidate,
  input  logic [SEED_W-1:0]   witness_seed,
  input  logic                last_round,
  input  logic                take,
  output eng_stat_t           stat
);

  eng_state_t state_r, state_nxt;

  logic              kind_r, kind_nxt;
  logic              last_r, last_nxt;
  logic              pass_r, pass_nxt;
  num_t              p_r, p_nxt;
  num_t              z_r, z_nxt;
  num_t              e_r, e_nxt;
  num_t              t_r, t_nxt;
  num_t              base_r, base_nxt;
  num_t              x_r, x_nxt;
  num_t              acc_r, acc_nxt;
  num_t              my_r, my_nxt;
  logic [SEED_W-1:0] sd_r, sd_nxt;
  logic [CNT_W-1:0]  mcnt_r, mcnt_nxt;
  logic [CNT_W-1:0]  ecnt_r, ecnt_nxt;
  logic [SCNT_W-1:0] scnt_r, scnt_nxt;
  mul_use_t          use_r, use_nxt;

  num_t ua, ub, um, usum;
  logic ucin;

  logic small_p, even_fail, mr_more;

  assign small_p   = (p_r[NUMBER_BITS-1:1] == '0);
  assign even_fail = (kind_r == KIND_MR) && !p_r[0] && (p_r != num_t'(2));
  assign mr_more   = (t_r != z_r) && (x_r != num_t'(1)) && (x_r != z_r);

  // shared modular adder operand select
  always_comb begin
    ua   = acc_r;
    ub   = acc_r;
    ucin = 1'b0;
    um   = p_r;
    unique case (state_r)
      S_SMOD: begin
        ucin = sd_r[SEED_W-1];
        um   = z_r;
      end
      S_MADD: begin
        ub = (use_r == MP_MUL) ? base_r : x_r;
      end
      default: begin
      end
    endcase
  end

  ppt_modadd u_add (
    .a   (ua),
    .b   (ub),
    .cin (ucin),
    .m   (um),
    .sum (usum)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_PREP;
      S_PREP:  state_nxt = (small_p || even_fail) ? S_DONE : S_SMOD;
      S_SMOD:  if (scnt_r == SCNT_W'(1)) state_nxt = S_STRIP;
      S_STRIP: if (kind_r == KIND_FERMAT || e_r[0]) state_nxt = S_ESKIP;
      S_ESKIP: if (e_r[NUMBER_BITS-1]) state_nxt = S_MDBL;
      S_MDBL: begin
        if (my_r[NUMBER_BITS-1]) state_nxt = S_MADD;
        else if (mcnt_r == CNT_W'(1)) state_nxt = S_MDONE;
      end
      S_MADD:  state_nxt = (mcnt_r == CNT_W'(1)) ? S_MDONE : S_MDBL;
      S_MDONE: begin
        unique case (use_r)
          MP_SQ:   state_nxt = (e_r[NUMBER_BITS-1] || ecnt_r != CNT_W'(1)) ? S_MDBL : S_EVAL;
          MP_MUL:  state_nxt = (ecnt_r != CNT_W'(1)) ? S_MDBL : S_EVAL;
          MP_MR:   state_nxt = S_MRCHK;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_EVAL:  state_nxt = (kind_r == KIND_FERMAT) ? S_DONE : S_MRCHK;
      S_MRCHK: state_nxt = mr_more ? S_MDBL : S_DONE;
      S_DONE:  if (take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    kind_nxt = kind_r;
    last_nxt = last_r;
    pass_nxt = pass_r;
    p_nxt    = p_r;
    z_nxt    = z_r;
    e_nxt    = e_r;
    t_nxt    = t_r;
    base_nxt = base_r;
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    my_nxt   = my_r;
    sd_nxt   = sd_r;
    mcnt_nxt = mcnt_r;
    ecnt_nxt = ecnt_r;
    scnt_nxt = scnt_r;
    use_nxt  = use_r;
    unique case (state_r)
      S_IDLE: begin
        kind_nxt = kind;
        last_nxt = last_round;
        p_nxt    = candidate[NUMBER_BITS-1:0];
        sd_nxt   = witness_seed;
      end
      S_PREP: begin
        pass_nxt = 1'b0;
        z_nxt    = p_r - num_t'(1);
        e_nxt    = p_r - num_t'(1);
        acc_nxt  = '0;
        scnt_nxt = SCNT_W'(SEED_W);
      end
      // acc = seed mod z, one seed bit a cycle; the witness is acc plus one
      S_SMOD: begin
        acc_nxt  = usum;
        sd_nxt   = sd_r << 1;
        scnt_nxt = scnt_r - SCNT_W'(1);
      end
      // strip factors of two from the exponent (Miller-Rabin rounds only)
      S_STRIP: begin
        base_nxt = acc_r + num_t'(1);
        x_nxt    = num_t'(1);
        ecnt_nxt = CNT_W'(NUMBER_BITS);
        if (kind_r == KIND_MR && !e_r[0]) begin
          e_nxt = e_r >> 1;
        end else begin
          t_nxt = e_r;
        end
      end
      // skip leading zero exponent bits, then start the first square
      S_ESKIP: begin
        if (!e_r[NUMBER_BITS-1]) begin
          e_nxt    = e_r << 1;
          ecnt_nxt = ecnt_r - CNT_W'(1);
        end else begin
          acc_nxt  = '0;
          my_nxt   = x_r;
          mcnt_nxt = CNT_W'(NUMBER_BITS);
          use_nxt  = MP_SQ;
        end
      end
      S_MDBL: begin
        acc_nxt = usum;
        if (!my_r[NUMBER_BITS-1]) begin
          my_nxt   = my_r << 1;
          mcnt_nxt = mcnt_r - CNT_W'(1);
        end
      end
      S_MADD: begin
        acc_nxt  = usum;
        my_nxt   = my_r << 1;
        mcnt_nxt = mcnt_r - CNT_W'(1);
      end
      S_MDONE: begin
        x_nxt    = acc_r;
        my_nxt   = acc_r;
        mcnt_nxt = CNT_W'(NUMBER_BITS);
        acc_nxt  = '0;
        unique case (use_r)
          MP_SQ: begin
            if (e_r[NUMBER_BITS-1]) begin
              use_nxt = MP_MUL;
            end else begin
              e_nxt    = e_r << 1;
              ecnt_nxt = ecnt_r - CNT_W'(1);
            end
          end
          MP_MUL: begin
            use_nxt  = MP_SQ;
            e_nxt    = e_r << 1;
            ecnt_nxt = ecnt_r - CNT_W'(1);
          end
          MP_MR: begin
            t_nxt = t_r << 1;
          end
          default: begin
          end
        endcase
      end
      S_EVAL: begin
        pass_nxt = (x_r == num_t'(1));
      end
      // Miller-Rabin squaring loop
      S_MRCHK: begin
        acc_nxt  = '0;
        my_nxt   = x_r;
        mcnt_nxt = CNT_W'(NUMBER_BITS);
        use_nxt  = MP_MR;
        pass_nxt = !((x_r != z_r) && !t_r[0]);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    last_r <= last_nxt;
    pass_r <= pass_nxt;
    p_r    <= p_nxt;
    z_r    <= z_nxt;
    e_r    <= e_nxt;
    t_r    <= t_nxt;
    base_r <= base_nxt;
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    my_r   <= my_nxt;
    sd_r   <= sd_nxt;
    mcnt_r <= mcnt_nxt;
    ecnt_r <= ecnt_nxt;
    scnt_r <= scnt_nxt;
    use_r  <= use_nxt;
  end

  // status outputs
  always_comb begin
    stat.idle = (state_r == S_IDLE);
    stat.done = (state_r == S_DONE);
    stat.pass = pass_r;
    stat.last = last_r;
  end

`ifndef NO_ASSERTIONS
  // multiply accumulator stays reduced
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MDBL || state_r == S_MADD) |-> (acc_r < p_r))
    else $error("accumulator not reduced modulo candidate");

  // witness lies in 1 .. p-1
  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ESKIP) |-> (base_r != '0 && base_r <= z_r))
    else $error("witness out of range");

  // squaring loop works on reduced values
  a_x_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MRCHK) |-> (x_r < p_r))
    else $error("square result not reduced");

  // a finished round waits until the top level takes it
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !take) |=> (state_r == S_DONE && $stable(pass_r)))
    else $error("round verdict dropped");
`endif

endmodule

### hdl/probabilistic_primality_test.sv
// ----------------------------------------------------------------------------
// probabilistic_primality_test
// Miller-Rabin / Fermat primality tester, one test round per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one round: kind (0 Miller-Rabin, 1 Fermat), candidate
//   (low NUMBER_BITS bits used), witness_seed and last_round. Verdicts of
//   rounds are ANDed; the round marked last emits probably_prime on out_res
//   and restarts the running verdict at one.
//   One modular multiply walks the NUMBER_BITS bits of its operand on the
//   single shared modular adder (a double per bit plus an add per set
//   bit). A full-width exponent is up to 2*NUMBER_BITS multiplies;
//   candidates below two, and even candidates other than two in
//   Miller-Rabin rounds, are rejected before any multiply.
//   in_req.ready is high only while the sequencer is idle.
//   The verdict sits in an output register; a new request is accepted while
//   it waits, and a later last round holds until out_res.ready frees it.
//   Reset (rst_n low, synchronous) idles the sequencer, empties the output
//   and sets the running verdict to one.
// ----------------------------------------------------------------------------
module probabilistic_primality_test
  import ppt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  ppt_in_if.sink           in_req,
  ppt_out_if.source        out_res
);

  eng_stat_t stat;
  logic      start;
  logic      take;
  logic      round_v;
  logic      verdict_r;
  logic      out_valid_r;
  logic      out_pp_r;

  assign in_req.ready = stat.idle;
  assign start        = in_req.valid && stat.idle;

  // a last round needs a free output slot
  assign take    = stat.done && (!stat.last || !out_valid_r || out_res.ready);
  assign round_v = verdict_r & stat.pass;

  ppt_engine u_eng (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .kind         (in_req.kind),
    .candidate    (in_req.candidate),
    .witness_seed (in_req.witness_seed),
    .last_round   (in_req.last_round),
    .take         (take),
    .stat         (stat)
  );

  // running verdict and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verdict_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // a new verdict may load while the old one leaves
      priority if (take && stat.last) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        if (stat.last) begin
          verdict_r <= 1'b1;
        end else begin
          verdict_r <= round_v;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && stat.last) out_pp_r <= round_v;
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.probably_prime = out_pp_r;

endmodule

### dv/probabilistic_primality_test_tb.sv
// ----------------------------------------------------------------------------
// probabilistic_primality_test_tb
// Drives round requests into the primality tester and checks each verdict
// against a behavioral predictor of the Miller-Rabin and Fermat rounds.
// ----------------------------------------------------------------------------
module probabilistic_primality_test_tb;
  import ppt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ppt_in_if  in_req ();
  ppt_out_if out_res ();

  probabilistic_primality_test dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always #4 clk = ~clk;

  // verdicts awaiting their result
  logic verdict_q[$];
  logic running_ok;
  int   errors;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   recv_hold;
  int   quiet_cycles;

  // ---- predictor ----
  function automatic logic [63:0] num_mask();
    return {64{1'b1}} >> (64 - NUMBER_BITS);
  endfunction

  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] prod;
    prod = 128'(x) * 128'(y);
    return 64'(prod % 128'(m));
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] r;
    logic [63:0] base;
    r = 64'd1 % m;
    base = b % m;
    for (int i = 63; i >= 0; i--) begin
      r = mulmod(r, r, m);
      if (e[i]) r = mulmod(r, base, m);
    end
    return r;
  endfunction

  function automatic bit round_passes(logic k, logic [63:0] cand, logic [30:0] seed);
    logic [63:0] p, z, d, a, x, t;
    p = cand & num_mask();
    if (p < 2) return 1'b0;
    z = p - 1;
    a = (64'(seed) % z) + 1;
    if (k == KIND_FERMAT) return powmod(a, z, p) == 64'd1;
    if (p != 2 && !p[0]) return 1'b0;
    d = z;
    while (d != 0 && !d[0]) d = d >> 1;
    x = powmod(a, d, p);
    t = d;
    while (t != z && x != 1 && x != z) begin
      x = mulmod(x, x, p);
      t = t << 1;
    end
    return !(x != z && !t[0]);
  endfunction

  // ---- sender ----
  // valid stays up after the accept; the next request or the end of the
  // run replaces or drops it in the same time step
  task automatic send_round(logic k, logic [63:0] cand, logic [30:0] seed, logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.kind <= k;
    in_req.candidate <= cand;
    in_req.witness_seed <= seed;
    in_req.last_round <= last;
    // ready is stable between the falling and the next rising edge
    do @(negedge clk); while (!in_req.ready);
    @(posedge clk);
    running_ok = running_ok & round_passes(k, cand, seed);
    if (last) begin
      verdict_q.push_back(running_ok);
      running_ok = 1'b1;
    end
  endtask

  // ---- receiver ready ----
  always @(posedge clk) begin
    if (recv_hold) out_res.ready <= 1'b0;
    else out_res.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  // ---- result checker and watchdog ----
  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, actual %0b", $time, out_res.probably_prime);
        errors++;
      end else begin
        if (out_res.probably_prime !== verdict_q[0]) begin
          $display("%0t: probably_prime mismatch, expected %0b actual %0b",
                   $time, verdict_q[0], out_res.probably_prime);
          errors++;
        end
        void'(verdict_q.pop_front());
      end
    end
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready) || !rst_n)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 200000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // random candidate, mostly odd and of small widths to keep rounds short
  function automatic logic [63:0] rand_cand();
    logic [63:0] c;
    int w;
    w = ($urandom_range(9) == 0) ? 64 : $urandom_range(16, 3);
    c = {$urandom, $urandom};
    c = c >> (64 - w);
    if ($urandom_range(3) != 0) c[0] = 1'b1;
    return c;
  endfunction

  // ---- tests ----
  task automatic test_directed();
    logic k;
    for (int i = 0; i < 2; i++) begin
      k = i[0];
      send_round(k, 64'd0, 31'd5, 1'b1);
      send_round(k, 64'd1, 31'h7fffffff, 1'b1);
      send_round(k, 64'd2, 31'd0, 1'b1);
      send_round(k, 64'd4, 31'd1, 1'b1);
      send_round(k, 64'd97, 31'h7fffffff, 1'b1);
      send_round(k, 64'd561, 31'd1234, 1'b1);
      send_round(k, 64'hffffffffffffffc5, 31'h55555555, 1'b1);
      send_round(k, 64'hffffffffffffffff, 31'd3, 1'b1);
    end
    // verdict accumulates across rounds: pass, fail, pass -> fail
    send_round(KIND_MR, 64'd13, 31'd2, 1'b0);
    send_round(KIND_MR, 64'd15, 31'd6, 1'b0);
    send_round(KIND_FERMAT, 64'd13, 31'd2, 1'b1);
    send_round(KIND_MR, 64'd7, 31'd3, 1'b0);
    send_round(KIND_FERMAT, 64'd7, 31'd4, 1'b1);
  endtask

  task automatic test_random(int n);
    logic [63:0] c;
    int rounds;
    while (n > 0) begin
      c = rand_cand();
      rounds = $urandom_range(3, 1);
      for (int r = 0; r < rounds; r++) begin
        if ($urandom_range(9) == 0) c = rand_cand();
        send_round(1'($urandom), c, 31'($urandom), r == rounds - 1);
        n--;
      end
    end
  endtask

  // receiver stalls while the sender keeps pushing last rounds
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (4000) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_round(KIND_MR, 64'd3 + 2 * i, 31'($urandom), 1'b1);
    join
  endtask

  initial begin
    in_req.valid = 1'b0;
    in_req.kind = KIND_MR;
    in_req.candidate = '0;
    in_req.witness_seed = '0;
    in_req.last_round = 1'b0;
    out_res.ready = 1'b0;
    running_ok = 1'b1;
    errors = 0;
    quiet_cycles = 0;
    recv_hold = 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 47;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(25);
    send_idle_pct = 47;
    recv_idle_pct = 27;
    test_random(25);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(23);
    in_req.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

### sim.f
hdl/ppt_pkg.sv
hdl/ppt_if.sv
hdl/ppt_modadd.sv
hdl/ppt_engine.sv
hdl/probabilistic_primality_test.sv
dv/probabilistic_primality_test_tb.sv
